// ===== rtl/wma_pkg.sv =====
// Shared constants and control types for the warm-up moving average block.
`timescale 1ns / 1ps
`default_nettype none
package wma_pkg;

	localparam int WINDOW   = 8;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
	localparam int STEP_W   = $clog2(SUM_W);

	localparam logic ACT_FILTER = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef struct packed {
		logic clear;
		logic capture;
		logic update;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_full;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/wma_in_if.sv =====
// Input channel: action and sample with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface wma_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [wma_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/wma_out_if.sv =====
// Output channel: average with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface wma_out_if;
	logic                          valid;
	logic                          ready;
	logic [wma_pkg::SAMPLE_W-1:0]  average;

	modport source (output valid, output average, input ready);
	modport sink   (input valid, input average, output ready);
endinterface
`default_nettype wire

// ===== rtl/wma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wma_ctrl.sv =====
// Sequencer: accept, ring update, iterative divide, result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module wma_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_action,
	output logic                  in_ready,
	input  wire wma_pkg::status_t status,
	output wma_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_action == wma_pkg::ACT_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				// wait until the previous beat has left the output register
				if (!status.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wma_dp.sv =====
// Datapath: sample ring, running sum, fill count, restoring divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module wma_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wma_pkg::cmd_t                cmd,
	output wma_pkg::status_t                  status,
	input  wire logic [wma_pkg::SAMPLE_W-1:0] in_sample,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [wma_pkg::SAMPLE_W-1:0] out_average
);

	localparam int IDX_W    = wma_pkg::IDX_W;
	localparam int CNT_W    = wma_pkg::CNT_W;
	localparam int SUM_W    = wma_pkg::SUM_W;
	localparam int SAMPLE_W = wma_pkg::SAMPLE_W;
	localparam int STEP_W   = wma_pkg::STEP_W;

	logic [IDX_W-1:0]    write_index_q;
	logic [CNT_W-1:0]    fill_count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] old_sample;

	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    divisor_q;
	logic [STEP_W-1:0]   step_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] average_q;

	logic                ring_full;
	logic [CNT_W-1:0]    count_next;
	logic [SUM_W-1:0]    sum_next;
	logic [IDX_W-1:0]    index_next;
	logic [CNT_W:0]      rem_shift;
	logic [CNT_W:0]      rem_diff;
	logic                quo_bit;

	wma_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(wma_pkg::WINDOW)
	) u_ring (
		.clk    (clk),
		.wr_en  (cmd.update),
		.wr_addr(write_index_q),
		.wr_data(sample_q),
		.rd_en  (cmd.capture),
		.rd_addr(write_index_q),
		.rd_data(old_sample)
	);

	always_comb begin
		ring_full  = (fill_count_q == CNT_W'(wma_pkg::WINDOW));
		count_next = ring_full ? fill_count_q : fill_count_q + CNT_W'(1);
		// drop the overwritten sample only once every slot holds one
		sum_next   = sum_q - (ring_full ? SUM_W'(old_sample) : SUM_W'(0)) + SUM_W'(sample_q);
		index_next = (write_index_q == IDX_W'(wma_pkg::WINDOW - 1)) ?
			IDX_W'(0) : write_index_q + IDX_W'(1);

		rem_shift = {rem_q, quo_q[SUM_W-1]};
		rem_diff  = rem_shift - {1'b0, divisor_q};
		quo_bit   = (rem_shift >= {1'b0, divisor_q});
	end

	assign status.div_last = (step_q == STEP_W'(SUM_W - 1));
	assign status.out_full = out_valid_q;

	assign out_valid   = out_valid_q;
	assign out_average = average_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			fill_count_q  <= '0;
			sum_q         <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.clear) begin
				write_index_q <= '0;
				fill_count_q  <= '0;
				sum_q         <= '0;
			end else if (cmd.update) begin
				write_index_q <= index_next;
				fill_count_q  <= count_next;
				sum_q         <= sum_next;
			end

			if (cmd.update) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
		end

		if (cmd.update) begin
			quo_q     <= sum_next;
			rem_q     <= '0;
			divisor_q <= count_next;
		end else if (cmd.div_step) begin
			// one restoring step: shift in the next dividend bit, subtract if it fits
			rem_q <= quo_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], quo_bit};
		end

		if (cmd.load_out) begin
			average_q <= quo_q[SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/warmup_moving_average_top.sv =====
// Top level of the warm-up moving average filter.
//
// Each sample beat stores the sample in an eight-entry ring, updates the
// running sum and returns the truncated mean of the samples held, divided by
// the number seen so far during warm-up. After a sample beat is accepted, the
// steps before the next beat can be taken are: read the slot being
// overwritten, update the ring and sum, run the one-bit-per-cycle restoring
// divider (one step per bit of the running sum), and load the output register
// once the previous result has been taken. A clear beat empties the filter
// and returns nothing. The output register holds a result until it is taken
// while the next beat is already being worked on.
`timescale 1ns / 1ps
`default_nettype none
module warmup_moving_average_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wma_in_if.sink     in_ch,
	wma_out_if.source  out_ch
);

	wma_pkg::cmd_t    cmd;
	wma_pkg::status_t status;

	wma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_action(in_ch.action),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	wma_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_sample  (in_ch.sample),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_average(out_ch.average)
	);

endmodule
`default_nettype wire

// ===== tb/wma_average_monitor.sv =====
// Watches both channels of the moving average filter, predicts each average and compares.
`timescale 1ns / 1ps
module wma_average_monitor import wma_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                in_action,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [SAMPLE_W-1:0] out_average,
	output int                  mismatches,
	output int                  outstanding
);

	logic [SAMPLE_W-1:0] window_ring [WINDOW];
	logic [IDX_W-1:0]    window_wr_idx;
	logic [CNT_W-1:0]    window_fill;
	logic [SUM_W-1:0]    window_sum;

	logic [SAMPLE_W-1:0] expected_averages [$];
	int                  error_count;
	int                  pending_count;

	assign mismatches  = error_count;
	assign outstanding = pending_count;

	function automatic void window_clear();
		for (int i = 0; i < WINDOW; i++) begin
			window_ring[i] = '0;
		end
		window_wr_idx = '0;
		window_fill   = '0;
		window_sum    = '0;
	endfunction

	// Store one sample and return the truncated mean of what the window holds.
	function automatic logic [SAMPLE_W-1:0] window_push_sample(logic [SAMPLE_W-1:0] smp);
		logic [SUM_W-1:0] quotient;
		if (int'(window_fill) < WINDOW) begin
			window_fill = window_fill + 1'b1;
		end else begin
			// drop the oldest sample once the ring is full
			window_sum = window_sum - SUM_W'(window_ring[window_wr_idx]);
		end
		window_ring[window_wr_idx] = smp;
		window_sum = window_sum + SUM_W'(smp);
		if (window_wr_idx == IDX_W'(WINDOW - 1)) begin
			window_wr_idx = '0;
		end else begin
			window_wr_idx = window_wr_idx + 1'b1;
		end
		quotient = window_sum / SUM_W'(window_fill);
		return quotient[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			window_clear();
			expected_averages.delete();
			error_count   = 0;
			pending_count = 0;
		end else begin
			// compare the result beat before taking in a new sample beat
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					if (error_count < 10)
						$display("%0t: average %0d arrived with none pending", $time,
							out_average);
					error_count++;
				end else begin
					want = expected_averages.pop_front();
					if (want !== out_average) begin
						if (error_count < 10)
							$display("%0t: average mismatch: expected %0d, got %0d", $time,
								want, out_average);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_action == ACT_CLEAR) begin
					window_clear();
				end else begin
					expected_averages.push_back(window_push_sample(in_sample));
				end
			end
			pending_count = expected_averages.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, handshake timing and verdict for the warm-up moving average filter.
`timescale 1ns / 1ps
module tb_top;
	import wma_pkg::*;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   beats_sent;
	bit   hold_done;

	wma_in_if  in_ch ();
	wma_out_if out_ch ();

	warmup_moving_average_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	wma_average_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_action   (in_ch.action),
		.in_sample   (in_ch.sample),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_average (out_ch.average),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// Offer one beat at the falling edge and hold it until accepted.
	task automatic send_beat(input logic act, input logic [SAMPLE_W-1:0] smp);
		@(negedge clk);
		in_ch.valid  = 1'b1;
		in_ch.action = act;
		in_ch.sample = smp;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic idle_cycles(input int n);
		@(negedge clk);
		in_ch.valid  = 1'b0;
		in_ch.action = 1'($urandom);
		in_ch.sample = SAMPLE_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 3))
			0: begin
				return SAMPLE_W'($urandom_range(0, 15));
			end
			1: begin
				return SAMPLE_W'($urandom_range(65520, 65535));
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	// Result side: switch between stall patterns; once, hold off long enough to back up the input.
	initial begin
		int mode;
		int span;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && beats_sent >= 300) begin
				hold_done = 1'b1;
				@(negedge clk);
				out_ch.ready = 1'b0;
				repeat (399) @(negedge clk);
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: begin
						out_ch.ready = 1'b1;
					end
					1: begin
						out_ch.ready = 1'($urandom_range(0, 1));
					end
					default: begin
						out_ch.ready = ($urandom_range(0, 4) == 0);
					end
				endcase
			end
		end
	end

	initial begin
		int  burst;
		int  gap;
		int  sent;
		bit  paused;
		logic act;
		in_ch.valid  = 1'b0;
		in_ch.action = ACT_FILTER;
		in_ch.sample = '0;
		beats_sent   = 0;
		hold_done    = 1'b0;
		arst_n       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// warm up at full scale, wrap the ring, then let zeros push the maximum out
		for (int i = 0; i < 9; i++) send_beat(ACT_FILTER, 16'hFFFF);
		send_beat(ACT_FILTER, 16'h0000);
		send_beat(ACT_FILTER, 16'h0000);
		send_beat(ACT_CLEAR, 16'hFFFF);
		// clear an already empty filter
		send_beat(ACT_CLEAR, 16'h0000);
		// truncation during warm-up
		send_beat(ACT_FILTER, 16'd1);
		send_beat(ACT_FILTER, 16'd2);
		send_beat(ACT_FILTER, 16'd3);
		send_beat(ACT_FILTER, 16'd0);
		send_beat(ACT_FILTER, 16'h8000);
		send_beat(ACT_FILTER, 16'h7FFF);
		send_beat(ACT_CLEAR, 16'h5A5A);
		send_beat(ACT_FILTER, 16'hA5A5);
		idle_cycles(1);
		wait (outstanding == 0);

		sent   = 0;
		paused = 1'b0;
		while (sent < 930) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				act = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_FILTER;
				send_beat(act, pick_sample());
				sent++;
			end
			if (!paused && sent >= 600) begin
				paused = 1'b1;
				idle_cycles(1);
				wait (outstanding == 0);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) idle_cycles(gap);
		end

		idle_cycles(1);
		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
